// ===== sv/ffsa_pkg.sv =====
package ffsa_pkg;

	localparam int MAX_SLOTS_DEF  = 256;
	localparam int OWNER_BITS_DEF = 16;
	localparam int QUEUE_DEPTH    = 2;
	localparam int GROUP_SIZE     = 16;
	localparam int CNT_W          = 9;

	localparam logic [1:0] MODE_RESERVE = 2'd0;
	localparam logic [1:0] MODE_RELEASE = 2'd1;
	localparam logic [1:0] MODE_QUERY   = 2'd2;

	localparam logic [2:0] ERR_OK           = 3'd0;
	localparam logic [2:0] ERR_NO_TABLE     = 3'd1;
	localparam logic [2:0] ERR_FULL         = 3'd2;
	localparam logic [2:0] ERR_BAD_SLOT     = 3'd3;
	localparam logic [2:0] ERR_NOT_OCCUPIED = 3'd4;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] owner_id;
		logic [8:0]  slot_number;
	} item_t;

	typedef struct packed {
		logic [2:0]  error_code;
		logic [8:0]  granted_slot;
		logic [15:0] slot_owner;
		logic        slot_occupied;
		logic [8:0]  free_count;
		logic [8:0]  used_count;
	} result_t;

	typedef enum logic [1:0] {
		KIND_DONE    = 2'd0,
		KIND_RESERVE = 2'd1,
		KIND_RELEASE = 2'd2,
		KIND_QUERY   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  err;
		logic [15:0] owner_id;
		logic [8:0]  slot_idx;
	} cmd_t;

	typedef struct packed {
		logic       clear;
		logic [8:0] cap;
	} cfg_t;

endpackage

// ===== sv/ffsa_fifo.sv =====
module ffsa_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = ffsa_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]  mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              wr_en, rd_en;

	assign full  = (fill_q == FILL_W'(DEPTH));
	assign empty = (fill_q == '0);
	assign wr_en = push && !full;
	assign rd_en = pop && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (wr_en && !rd_en) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (rd_en && !wr_en) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== sv/ffsa_front.sv =====
module ffsa_front (
	input  ffsa_pkg::item_t item,
	input  ffsa_pkg::cfg_t  cfg,
	output ffsa_pkg::cmd_t  cmd
);

	always_comb begin
		cmd.kind     = ffsa_pkg::KIND_DONE;
		cmd.err      = ffsa_pkg::ERR_OK;
		cmd.owner_id = item.owner_id;
		cmd.slot_idx = item.slot_number - 9'd1;
		if (cfg.cap == '0) begin
			cmd.err = ffsa_pkg::ERR_NO_TABLE;
		end else begin
			unique case (item.mode) inside
				ffsa_pkg::MODE_RESERVE: begin
					cmd.kind = ffsa_pkg::KIND_RESERVE;
				end
				ffsa_pkg::MODE_RELEASE, ffsa_pkg::MODE_QUERY: begin
					if (item.slot_number == '0 || item.slot_number > cfg.cap) begin
						cmd.err = ffsa_pkg::ERR_BAD_SLOT;
					end else if (item.mode == ffsa_pkg::MODE_RELEASE) begin
						cmd.kind = ffsa_pkg::KIND_RELEASE;
					end else begin
						cmd.kind = ffsa_pkg::KIND_QUERY;
					end
				end
				// unused mode: counts only
				default: begin
					cmd.kind = ffsa_pkg::KIND_DONE;
				end
			endcase
		end
	end

endmodule

// ===== sv/ffsa_back.sv =====
module ffsa_back #(
	parameter int MAX_SLOTS  = ffsa_pkg::MAX_SLOTS_DEF,
	parameter int OWNER_BITS = ffsa_pkg::OWNER_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ffsa_pkg::cfg_t    cfg,
	input  ffsa_pkg::cmd_t    cmd,
	input  logic              cmd_empty,
	output logic              cmd_pop,
	output ffsa_pkg::result_t res,
	output logic              res_push,
	input  logic              res_full
);

	localparam int SLOT_W = $clog2(MAX_SLOTS);
	localparam int GRP    = ffsa_pkg::GROUP_SIZE;
	localparam int BIT_W  = $clog2(GRP);
	localparam int NGRP   = (MAX_SLOTS + GRP - 1) / GRP;
	localparam int GRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
	localparam int PAD_W  = NGRP * GRP;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_GROUP = 5'b00010,
		ST_BIT   = 5'b00100,
		ST_READ  = 5'b01000,
		ST_PUSH  = 5'b10000
	} state_t;

	state_t                              state_q, state_d;
	logic [MAX_SLOTS-1:0]                occ_q;
	logic [ffsa_pkg::CNT_W-1:0]          used_q;
	ffsa_pkg::cmd_t                      cmd_q;
	ffsa_pkg::result_t                   res_q;
	logic [GRP_W-1:0]                    grp_q, grp_sel;
	logic                                occ_hit_q;
	logic [OWNER_BITS-1:0]               owner_rd_q;
	logic [OWNER_BITS-1:0]               owner_mem [MAX_SLOTS];
	logic [PAD_W-1:0]                    occ_pad;
	logic [NGRP-1:0]                     grp_full;
	logic [GRP-1:0]                      grp_bits;
	logic [BIT_W-1:0]                    bit_sel;
	logic [SLOT_W-1:0]                   alloc_idx, rd_idx, held_idx;
	logic                                occ_set, occ_clr, table_full;
	logic [2:0]                          pop_err;

	// pad past the last slot reads as occupied so it is never granted
	always_comb begin
		occ_pad = '1;
		occ_pad[MAX_SLOTS-1:0] = occ_q;
	end

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_full[g] = &occ_pad[g*GRP +: GRP];
		end
	end

	always_comb begin
		grp_sel = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (!grp_full[g]) begin
				grp_sel = GRP_W'(g);
			end
		end
	end

	assign grp_bits = occ_pad[grp_q*GRP +: GRP];

	always_comb begin
		bit_sel = '0;
		for (int b = GRP - 1; b >= 0; b--) begin
			if (!grp_bits[b]) begin
				bit_sel = BIT_W'(b);
			end
		end
	end

	assign alloc_idx  = SLOT_W'({grp_q, bit_sel});
	assign rd_idx     = SLOT_W'(cmd.slot_idx);
	assign held_idx   = SLOT_W'(cmd_q.slot_idx);
	assign table_full = (used_q >= cfg.cap);
	assign pop_err    = (cmd.kind == ffsa_pkg::KIND_RESERVE && table_full) ?
		ffsa_pkg::ERR_FULL : cmd.err;

	always_comb begin
		state_d  = state_q;
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		occ_set  = 1'b0;
		occ_clr  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					case (cmd.kind) inside
						ffsa_pkg::KIND_RESERVE: begin
							state_d = table_full ? ST_PUSH : ST_GROUP;
						end
						ffsa_pkg::KIND_RELEASE, ffsa_pkg::KIND_QUERY: begin
							state_d = ST_READ;
						end
						default: begin
							state_d = ST_PUSH;
						end
					endcase
				end
			end
			ST_GROUP: begin
				state_d = ST_BIT;
			end
			ST_BIT: begin
				occ_set = 1'b1;
				state_d = ST_PUSH;
			end
			ST_READ: begin
				occ_clr = occ_hit_q && (cmd_q.kind == ffsa_pkg::KIND_RELEASE);
				state_d = ST_PUSH;
			end
			ST_PUSH: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			occ_q   <= '0;
			used_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cfg.clear) begin
				occ_q  <= '0;
				used_q <= '0;
			end else if (occ_set) begin
				occ_q[alloc_idx] <= 1'b1;
				used_q           <= used_q + ffsa_pkg::CNT_W'(1);
			end else if (occ_clr) begin
				occ_q[held_idx] <= 1'b0;
				used_q          <= used_q - ffsa_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q     <= cmd;
			occ_hit_q <= occ_q[rd_idx];
			res_q     <= '{pop_err, 9'd0, 16'd0, 1'b0, 9'd0, 9'd0};
		end
		if (state_q == ST_GROUP) begin
			grp_q <= grp_sel;
		end
		if (occ_set) begin
			res_q.granted_slot <= ffsa_pkg::CNT_W'(alloc_idx) + ffsa_pkg::CNT_W'(1);
		end
		if (state_q == ST_READ) begin
			if (occ_hit_q) begin
				res_q.slot_owner    <= 16'(owner_rd_q);
				res_q.slot_occupied <= 1'b1;
			end else if (cmd_q.kind == ffsa_pkg::KIND_RELEASE) begin
				res_q.error_code <= ffsa_pkg::ERR_NOT_OCCUPIED;
			end
		end
	end

	// owner store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (occ_set) begin
			owner_mem[alloc_idx] <= OWNER_BITS'(cmd_q.owner_id);
		end
		if (cmd_pop) begin
			owner_rd_q <= owner_mem[rd_idx];
		end
	end

	always_comb begin
		res            = res_q;
		res.used_count = used_q;
		res.free_count = cfg.cap - used_q;
	end

`ifndef SYNTH
	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(occ_q) == int'(used_q))
		else $error("occupied count disagrees with occupancy bits");

	a_grant_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BIT) |-> !occ_q[alloc_idx])
		else $error("granted slot already occupied");

	a_grant_sets: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BIT && !cfg.clear) |=> occ_q[$past(alloc_idx)])
		else $error("granted slot not marked occupied");

	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		occ_clr |=> !occ_q[$past(held_idx)])
		else $error("released slot still occupied");
`endif

endmodule

// ===== sv/first_free_seat_allocator.sv =====
// First-fit slot allocator.
// Input queue: drive item and push; the beat is taken when push is high and full is low.
// Result queue: while empty is low the oldest result sits on result; pop takes the beat.
// Every item yields exactly one result, in order.
// Config: cfg_data (capacity) is written when cfg_valid is high; cfg_ready is always high.
// A capacity write frees every slot in that same cycle; write it only while the block is idle.
// Capacity above MAX_SLOTS is used as MAX_SLOTS; capacity 0 rejects every item.
// The back sequencer runs one item at a time: reserve goes through group search, then
// bit search with store, then result; release and query through owner read, update and
// result; rejected items and unused modes go straight to the result.
// The front and a 2-entry command queue keep taking items while the back works, and a
// 2-entry result queue lets the back finish while the receiver stalls; when the command
// queue fills, full rises and items wait.
// Reset empties both queues, frees every slot and sets capacity to 0.
module first_free_seat_allocator #(
	parameter int MAX_SLOTS  = ffsa_pkg::MAX_SLOTS_DEF,
	parameter int OWNER_BITS = ffsa_pkg::OWNER_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ffsa_pkg::item_t   item,
	input  logic              push,
	output logic              full,
	output ffsa_pkg::result_t result,
	output logic              empty,
	input  logic              pop,
	input  logic [8:0]        cfg_data,
	input  logic              cfg_valid,
	output logic              cfg_ready
);

	localparam int CMD_W = $bits(ffsa_pkg::cmd_t);
	localparam int RES_W = $bits(ffsa_pkg::result_t);

	logic [ffsa_pkg::CNT_W-1:0] cap_q;
	ffsa_pkg::cfg_t             cfg;
	ffsa_pkg::cmd_t             cmd_in, cmd_out;
	ffsa_pkg::result_t          res;
	logic [CMD_W-1:0]           cmd_rdata;
	logic [RES_W-1:0]           res_rdata;
	logic                       cmd_empty, cmd_pop, res_push, res_full;

	assign cfg_ready = 1'b1;
	assign cfg.clear = cfg_valid && cfg_ready;
	assign cfg.cap   = cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '0;
		end else if (cfg.clear) begin
			// clamp to the table size
			if (32'(cfg_data) > 32'(MAX_SLOTS)) begin
				cap_q <= ffsa_pkg::CNT_W'(MAX_SLOTS);
			end else begin
				cap_q <= cfg_data;
			end
		end
	end

	ffsa_front u_front (
		.item (item),
		.cfg  (cfg),
		.cmd  (cmd_in)
	);

	ffsa_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (ffsa_pkg::QUEUE_DEPTH)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.wdata  (cmd_in),
		.pop    (cmd_pop),
		.empty  (cmd_empty),
		.rdata  (cmd_rdata)
	);

	assign cmd_out = ffsa_pkg::cmd_t'(cmd_rdata);

	ffsa_back #(
		.MAX_SLOTS  (MAX_SLOTS),
		.OWNER_BITS (OWNER_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res       (res),
		.res_push  (res_push),
		.res_full  (res_full)
	);

	ffsa_fifo #(
		.WIDTH (RES_W),
		.DEPTH (ffsa_pkg::QUEUE_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.full   (res_full),
		.wdata  (res),
		.pop    (pop),
		.empty  (empty),
		.rdata  (res_rdata)
	);

	assign result = ffsa_pkg::result_t'(res_rdata);

endmodule
